// File: rtl/ppcd_pkg.sv
// ----------------------------------------------------------------------------
// Packed pattern cell decoder package
// Shared beat types, configuration type, decode phases and stream constants.
// ----------------------------------------------------------------------------
package ppcd_pkg;

   localparam int MAX_LINES       = 256;
   localparam int MAX_TRACK_COUNT = 64;
   localparam int CELL_BYTES      = 7;

   localparam int LINE_POS_W  = $clog2(MAX_LINES + 1);
   localparam int TRACK_POS_W = $clog2(MAX_TRACK_COUNT + 1);

   localparam logic [7:0] BYTE_REPEAT = 8'hFF;
   localparam logic [6:0] FULL_MASK   = 7'h7F;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PACKED_MODE = 2'd0;
   localparam logic [1:0] CSR_LINES       = 2'd1;
   localparam logic [1:0] CSR_TRACKS      = 2'd2;

   typedef enum logic [1:0] {
      PH_HEAD             = 2'd0,
      PH_COUNT            = 2'd1,
      PH_HEAD_AFTER_COUNT = 2'd2,
      PH_GATHER           = 2'd3
   } phase_type;

   typedef struct packed {
      logic       packed_mode;
      logic [8:0] lines_in_pattern;
      logic [6:0] tracks_in_pattern;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [5:0] track_index;
      logic [7:0] first_line;
      logic [8:0] line_run;
      logic [6:0] column_mask;
      logic [7:0] col_0;
      logic [7:0] col_1;
      logic [7:0] col_2;
      logic [7:0] col_3;
      logic [7:0] col_4;
      logic [7:0] col_5;
      logic [7:0] col_6;
      logic       overrun;
   } rsp_beat_type;

endpackage

// File: rtl/packed_pattern_cell_decoder.sv
// ----------------------------------------------------------------------------
// Packed pattern cell decoder
// Turns a pattern byte stream into run-length cell writes on a track grid.
// ----------------------------------------------------------------------------
// The decoder takes one stream byte per clock on the req_ channel and gives at
// most one cell-write beat on the rsp_ channel for each byte, in stream order.
// A byte passes through an input register and then a single decode step that
// updates the stream state and loads the result register, so a result beat is
// presented from the result register; while the consumer keeps up, bytes can
// follow each other in every cycle; the single decode step sets that rate.
// While the consumer stalls, the result register holds one beat and the input
// register one more byte; the req_ side is then held off until the result beat
// is taken, even when the held byte would give no result. In packed mode a run
// is reported once with its line count, not line by line; there is no
// clearing pass after reset. The user writes configuration through the csr_
// port only while the decoder holds no byte and no result; this is unchecked.
// ----------------------------------------------------------------------------
module packed_pattern_cell_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ppcd_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ppcd_pkg::rsp_beat_type rsp_data,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [8:0]             csr_wdata
);

   // Configuration registers. Out-of-range values are clamped in the engine.
   logic       packed_mode_ff;
   logic [8:0] lines_ff;
   logic [6:0] tracks_ff;

   ppcd_pkg::cfg_type      cfg;
   logic                   in_valid;
   ppcd_pkg::req_beat_type in_beat;
   logic                   out_free;
   logic                   advance;
   logic                   res_valid;
   ppcd_pkg::rsp_beat_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         packed_mode_ff <= 1'b1;
         lines_ff       <= 9'd64;
         tracks_ff      <= 7'd8;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ppcd_pkg::CSR_PACKED_MODE: packed_mode_ff <= csr_wdata[0];
            ppcd_pkg::CSR_LINES:       lines_ff       <= csr_wdata;
            ppcd_pkg::CSR_TRACKS:      tracks_ff      <= csr_wdata[6:0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   assign cfg.packed_mode       = packed_mode_ff;
   assign cfg.lines_in_pattern  = lines_ff;
   assign cfg.tracks_in_pattern = tracks_ff;

   // A held byte is decoded as soon as the result register can take its
   // outcome, whether or not that outcome is a result beat.
   assign advance = in_valid && out_free;

   ppcd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_beat   (in_beat)
   );

   ppcd_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_beat   (in_beat),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   ppcd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A held byte is not dropped while the result side is stalled.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !advance) |=> in_valid)
      else $error("held input beat lost while stalled");

   // A decoded result always reaches the result register.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid) |=> rsp_valid)
      else $error("decoded result not presented");

   // A result beat leaves only when the consumer takes it.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_valid) && !$past(reset)) |-> $past(rsp_ready))
      else $error("result beat dropped without handshake");

   // Only an off-grid result carries an empty column mask.
   a_empty_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.column_mask == '0) |-> rsp_data.overrun)
      else $error("empty column mask without overrun");
`endif

endmodule

// File: rtl/ppcd_in_reg.sv
// ----------------------------------------------------------------------------
// Packed pattern cell decoder input register
// Holds one accepted request beat until the decode engine takes it.
// ----------------------------------------------------------------------------
module ppcd_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ppcd_pkg::req_beat_type req_data,
   input  logic                  advance,
   output logic                  in_valid,
   output ppcd_pkg::req_beat_type in_beat
);

   logic                   valid_ff;
   ppcd_pkg::req_beat_type beat_ff;

   assign req_ready = !valid_ff || advance;
   assign in_valid  = valid_ff;
   assign in_beat   = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         beat_ff <= req_data;
      end
   end

endmodule

// File: rtl/ppcd_engine.sv
// ----------------------------------------------------------------------------
// Packed pattern cell decoder engine
// Stream state registers and the combinational decode step for one byte.
// ----------------------------------------------------------------------------
module ppcd_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  ppcd_pkg::req_beat_type in_beat,
   input  ppcd_pkg::cfg_type      cfg,
   output logic                   res_valid,
   output ppcd_pkg::rsp_beat_type res
);

   localparam int LW = ppcd_pkg::LINE_POS_W;
   localparam int TW = ppcd_pkg::TRACK_POS_W;

   // Lowest set mask bit at or above the start slot; seven when none is left.
   function automatic logic [3:0] next_bit(logic [6:0] mask, logic [3:0] from);
      logic [3:0] hit;
      hit = 4'd7;
      for (int k = 6; k >= 0; k--) begin
         if (mask[k] && (4'(k) >= from)) begin
            hit = 4'(k);
         end
      end
      return hit;
   endfunction

   ppcd_pkg::phase_type phase_ff, phase_in;
   logic [8:0]          repeat_ff, repeat_in;
   logic [6:0]          mask_ff, mask_in;
   logic [7:0]          gather_ff [ppcd_pkg::CELL_BYTES];
   logic [7:0]          gather_in [ppcd_pkg::CELL_BYTES];
   logic [2:0]          slot_ff;
   logic [3:0]          slot_in;
   logic [LW-1:0]       line_ff, line_in;
   logic [TW-1:0]       track_ff, track_in;

   logic [LW-1:0] eff_lines;
   logic [TW-1:0] eff_tracks;
   logic [7:0]    b;

   logic          do_run;
   logic          run_write;
   logic [8:0]    run_len;
   logic [6:0]    run_mask;
   logic [LW-1:0] left;
   logic [8:0]    run;
   logic          ovf;

   always_comb begin
      if (cfg.lines_in_pattern == '0) begin
         eff_lines = LW'(1);
      end else if (32'(cfg.lines_in_pattern) > ppcd_pkg::MAX_LINES) begin
         eff_lines = LW'(ppcd_pkg::MAX_LINES);
      end else begin
         eff_lines = LW'(cfg.lines_in_pattern);
      end
      if (cfg.tracks_in_pattern == '0) begin
         eff_tracks = TW'(1);
      end else if (32'(cfg.tracks_in_pattern) > ppcd_pkg::MAX_TRACK_COUNT) begin
         eff_tracks = TW'(ppcd_pkg::MAX_TRACK_COUNT);
      end else begin
         eff_tracks = TW'(cfg.tracks_in_pattern);
      end
   end

   assign b = in_beat.data_byte;

   always_comb begin
      phase_in  = phase_ff;
      repeat_in = repeat_ff;
      mask_in   = mask_ff;
      gather_in = gather_ff;
      slot_in   = {1'b0, slot_ff};
      line_in   = line_ff;
      track_in  = track_ff;
      do_run    = 1'b0;
      run_write = 1'b0;
      run_len   = repeat_ff;
      run_mask  = '0;
      left      = '0;
      run       = '0;
      ovf       = 1'b0;
      res_valid = 1'b0;
      res       = '0;

      if (cfg.packed_mode) begin
         unique case (phase_ff)
            ppcd_pkg::PH_COUNT: begin
               repeat_in = {1'b0, b} + 9'd1;
               phase_in  = ppcd_pkg::PH_HEAD_AFTER_COUNT;
            end
            ppcd_pkg::PH_HEAD, ppcd_pkg::PH_HEAD_AFTER_COUNT: begin
               if (phase_ff == ppcd_pkg::PH_HEAD) begin
                  repeat_in = 9'd1;
               end
               if (phase_ff == ppcd_pkg::PH_HEAD && b == ppcd_pkg::BYTE_REPEAT) begin
                  phase_in = ppcd_pkg::PH_COUNT;
               end else begin
                  for (int k = 0; k < ppcd_pkg::CELL_BYTES; k++) begin
                     gather_in[k] = '0;
                  end
                  if (!b[7]) begin
                     // A plain head byte is column 0 of a full cell.
                     mask_in      = ppcd_pkg::FULL_MASK;
                     gather_in[0] = b;
                     slot_in      = 4'd1;
                     phase_in     = ppcd_pkg::PH_GATHER;
                  end else begin
                     mask_in = b[6:0];
                     if (b[6:0] == '0) begin
                        do_run    = 1'b1;
                        run_len   = repeat_in;
                        phase_in  = ppcd_pkg::PH_HEAD;
                        repeat_in = 9'd1;
                     end else begin
                        slot_in  = next_bit(b[6:0], 4'd0);
                        phase_in = ppcd_pkg::PH_GATHER;
                     end
                  end
               end
            end
            ppcd_pkg::PH_GATHER: begin
               if (slot_in < 4'd7) begin
                  gather_in[slot_in[2:0]] = b;
               end
               slot_in = next_bit(mask_ff, slot_in + 4'd1);
               if (slot_in >= 4'd7) begin
                  do_run    = 1'b1;
                  run_write = 1'b1;
                  run_len   = repeat_ff;
                  run_mask  = mask_ff;
                  phase_in  = ppcd_pkg::PH_HEAD;
                  repeat_in = 9'd1;
                  slot_in   = 4'd0;
               end
            end
            default: begin
               phase_in = ppcd_pkg::PH_HEAD;
            end
         endcase

         if (do_run) begin
            // A line position left past a lowered line count moves on first.
            if (track_in < eff_tracks && line_in >= eff_lines) begin
               line_in  = '0;
               track_in = track_in + TW'(1);
            end
            if (track_in >= eff_tracks) begin
               if (run_write) begin
                  res_valid    = 1'b1;
                  res.line_run = run_len;
                  res.overrun  = 1'b1;
               end
            end else begin
               left = eff_lines - line_in;
               if (LW'(run_len) > left) begin
                  run = 9'(left);
                  ovf = 1'b1;
               end else begin
                  run = run_len;
               end
               if (run_write) begin
                  res_valid       = 1'b1;
                  res.track_index = track_in[5:0];
                  res.first_line  = line_in[7:0];
                  res.line_run    = run;
                  res.column_mask = run_mask;
                  res.col_0       = gather_in[0] & {8{run_mask[0]}};
                  res.col_1       = gather_in[1] & {8{run_mask[1]}};
                  res.col_2       = gather_in[2] & {8{run_mask[2]}};
                  res.col_3       = gather_in[3] & {8{run_mask[3]}};
                  res.col_4       = gather_in[4] & {8{run_mask[4]}};
                  res.col_5       = gather_in[5] & {8{run_mask[5]}};
                  res.col_6       = gather_in[6] & {8{run_mask[6]}};
                  res.overrun     = ovf;
               end
               line_in = line_in + LW'(run);
               if (line_in >= eff_lines) begin
                  line_in  = '0;
                  track_in = track_in + TW'(1);
               end
            end
         end
      end else begin
         if (slot_in < 4'd7) begin
            gather_in[slot_in[2:0]] = b;
         end
         slot_in = slot_in + 4'd1;
         if (slot_in >= 4'd7) begin
            slot_in   = 4'd0;
            res_valid = 1'b1;
            if (track_in >= eff_tracks) begin
               track_in = '0;
               line_in  = line_in + LW'(1);
            end
            if (line_in >= eff_lines) begin
               line_in      = eff_lines;
               res.line_run = 9'd1;
               res.overrun  = 1'b1;
            end else begin
               res.track_index = track_in[5:0];
               res.first_line  = line_in[7:0];
               res.line_run    = 9'd1;
               res.column_mask = ppcd_pkg::FULL_MASK;
               res.col_0       = gather_in[0];
               res.col_1       = gather_in[1];
               res.col_2       = gather_in[2];
               res.col_3       = gather_in[3];
               res.col_4       = gather_in[4];
               res.col_5       = gather_in[5];
               res.col_6       = gather_in[6];
               track_in = track_in + TW'(1);
               if (track_in >= eff_tracks) begin
                  track_in = '0;
                  line_in  = line_in + LW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && in_beat.last_byte)) begin
         phase_ff  <= ppcd_pkg::PH_HEAD;
         repeat_ff <= 9'd1;
         mask_ff   <= '0;
         for (int k = 0; k < ppcd_pkg::CELL_BYTES; k++) begin
            gather_ff[k] <= '0;
         end
         slot_ff   <= '0;
         line_ff   <= '0;
         track_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         repeat_ff <= repeat_in;
         mask_ff   <= mask_in;
         gather_ff <= gather_in;
         slot_ff   <= slot_in[2:0];
         line_ff   <= line_in;
         track_ff  <= track_in;
      end
   end

endmodule

// File: rtl/ppcd_out_reg.sv
// ----------------------------------------------------------------------------
// Packed pattern cell decoder result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module ppcd_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   res_valid,
   input  ppcd_pkg::rsp_beat_type res,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ppcd_pkg::rsp_beat_type rsp_data
);

   logic                   valid_ff;
   ppcd_pkg::rsp_beat_type beat_ff;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= res_valid;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid) begin
         beat_ff <= res;
      end
   end

endmodule

// File: tb/packed_pattern_cell_decoder_tb.sv
// ----------------------------------------------------------------------------
// Packed pattern cell decoder testbench
// Streams pattern bytes in packed and raw mode, predicts every cell write and
// checks each result beat in order against that prediction or a typed-in one.
// ----------------------------------------------------------------------------
module packed_pattern_cell_decoder_tb;

   // Stimulus stops once about this many bytes have been accepted.
   localparam int TOTAL_BYTES  = 1225;
   // A byte that makes no result may still be in flight when the last result
   // has arrived, so the drain waits out DRAIN_CYCLES before any register
   // write.
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 400;

   // One row of the directed part: either a register write or a stream byte.
   // A byte row may carry its expected write typed in by hand.
   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [1:0]             index;
      logic [8:0]             value;
      ppcd_pkg::req_beat_type beat;
      logic                   typed;
      ppcd_pkg::rsp_beat_type result;
   } stim_row_type;

   logic                   clock;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   ppcd_pkg::req_beat_type req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   ppcd_pkg::rsp_beat_type rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [1:0]             csr_index    = ppcd_pkg::CSR_PACKED_MODE;
   logic [8:0]             csr_wdata    = '0;

   // Predictor copy of the registers and of the stream state.
   ppcd_pkg::cfg_type   cfg;
   ppcd_pkg::phase_type dec_phase;
   logic [8:0] rep_count;
   logic [6:0] run_mask;
   logic [7:0] col_bytes [ppcd_pkg::CELL_BYTES];
   logic [2:0] slot;
   logic [8:0] line_at;
   logic [6:0] track_at;

   // Cell writes predicted but not yet seen on the result channel.
   ppcd_pkg::rsp_beat_type pending_writes [$];
   stim_row_type directed_rows [$];

   int bytes_sent   = 0;
   int mismatches   = 0;
   // Percentage of cycles in which each side idles; zero for a quiet stretch.
   int idle_pct     = 19;
   bit hold_request = 1'b0;
   // Mirrors the value that the sender has scheduled on req_valid, so that
   // no second nonblocking write to it can land in the same time step.
   bit offering     = 1'b0;

   packed_pattern_cell_decoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the decoder hangs or loses a beat.
   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Register values outside the legal range are clamped by the decoder.
   function automatic int lines_eff();
      if (cfg.lines_in_pattern == 9'd0) return 1;
      if (cfg.lines_in_pattern > ppcd_pkg::MAX_LINES) return ppcd_pkg::MAX_LINES;
      return int'(cfg.lines_in_pattern);
   endfunction

   function automatic int tracks_eff();
      if (cfg.tracks_in_pattern == 7'd0) return 1;
      if (cfg.tracks_in_pattern > ppcd_pkg::MAX_TRACK_COUNT)
         return ppcd_pkg::MAX_TRACK_COUNT;
      return int'(cfg.tracks_in_pattern);
   endfunction

   // Column bytes are given with column 0 in the top byte.
   function automatic ppcd_pkg::rsp_beat_type pack_write(logic [5:0] trk,
                                                         logic [7:0] first,
                                                         logic [8:0] run,
                                                         logic [6:0] mask,
                                                         logic [55:0] cols,
                                                         logic ovr);
      return {trk, first, run, mask, cols, ovr};
   endfunction

   // A column whose mask bit is clear always reads zero.
   function automatic ppcd_pkg::rsp_beat_type write_from_bytes(logic [5:0] trk,
                                                               logic [7:0] first,
                                                               logic [8:0] run,
                                                               logic [6:0] mask,
                                                               logic ovr);
      logic [55:0] cols;
      cols = '0;
      for (int k = 0; k < ppcd_pkg::CELL_BYTES; k++)
         if (mask[k]) cols[55 - 8 * k -: 8] = col_bytes[k];
      return pack_write(trk, first, run, mask, cols, ovr);
   endfunction

   function automatic logic [2:0] next_set(logic [6:0] mask, int from);
      for (int k = from; k < ppcd_pkg::CELL_BYTES; k++)
         if (mask[k]) return 3'(k);
      return 3'd7;
   endfunction

   function automatic void restart_stream();
      dec_phase = ppcd_pkg::PH_HEAD;
      rep_count = 9'd1;
      run_mask  = '0;
      foreach (col_bytes[k]) col_bytes[k] = '0;
      slot      = '0;
      line_at   = '0;
      track_at  = '0;
   endfunction

   // Fills or skips a run of lines in packed mode. A filled run that starts past
   // the last track gives a flagged write at the origin and leaves the
   // position alone; a run past the last line of its track is clipped.
   task automatic advance_run(input logic [8:0] reps, input logic [6:0] mask,
                              input bit write, output bit produced,
                              output ppcd_pkg::rsp_beat_type result);
      int lines, tracks, run;
      bit ovf;
      lines    = lines_eff();
      tracks   = tracks_eff();
      produced = 1'b0;
      result   = '0;
      run      = int'(reps);
      ovf      = 1'b0;
      // A line count lowered under the current position moves to the next track.
      if (track_at < tracks && line_at >= lines) begin
         line_at  = '0;
         track_at = track_at + 7'd1;
      end
      if (track_at >= tracks) begin
         if (write) begin
            produced = 1'b1;
            result   = pack_write('0, '0, reps, '0, '0, 1'b1);
         end
      end else begin
         if (run > lines - int'(line_at)) begin
            run = lines - int'(line_at);
            ovf = 1'b1;
         end
         if (write) begin
            produced = 1'b1;
            result   = write_from_bytes(track_at[5:0], line_at[7:0], 9'(run), mask, ovf);
         end
         line_at = line_at + 9'(run);
         if (line_at >= lines) begin
            line_at  = '0;
            track_at = track_at + 7'd1;
         end
      end
   endtask

   // Works out the effect of one accepted stream byte.
   task automatic decode_byte(input ppcd_pkg::req_beat_type beat, output bit produced,
                              output ppcd_pkg::rsp_beat_type result);
      logic [7:0] b;
      int lines, tracks, nxt;
      b        = beat.data_byte;
      produced = 1'b0;
      result   = '0;
      lines    = lines_eff();
      tracks   = tracks_eff();
      if (cfg.packed_mode) begin
         case (dec_phase)
            ppcd_pkg::PH_COUNT: begin
               rep_count = {1'b0, b} + 9'd1;
               dec_phase = ppcd_pkg::PH_HEAD_AFTER_COUNT;
            end
            ppcd_pkg::PH_GATHER: begin
               // The byte lands at the current slot, even when the mode was
               // switched in the middle of a cell.
               if (slot < 3'd7) col_bytes[slot] = b;
               slot = next_set(run_mask, int'(slot) + 1);
               if (slot == 3'd7) begin
                  advance_run(rep_count, run_mask, 1'b1, produced, result);
                  dec_phase = ppcd_pkg::PH_HEAD;
                  rep_count = 9'd1;
                  slot      = '0;
               end
            end
            default: begin
               if (dec_phase == ppcd_pkg::PH_HEAD) rep_count = 9'd1;
               // Only a head right after a run may open a repeat prefix; a
               // second repeat byte after the count is a full-mask head.
               if (dec_phase == ppcd_pkg::PH_HEAD && b == ppcd_pkg::BYTE_REPEAT) begin
                  dec_phase = ppcd_pkg::PH_COUNT;
               end else begin
                  foreach (col_bytes[k]) col_bytes[k] = '0;
                  if (!b[7]) begin
                     run_mask     = ppcd_pkg::FULL_MASK;
                     col_bytes[0] = b;
                     slot         = 3'd1;
                     dec_phase    = ppcd_pkg::PH_GATHER;
                  end else begin
                     run_mask = b[6:0];
                     if (run_mask == 7'd0) begin
                        // An empty mask skips lines without any write.
                        advance_run(rep_count, 7'd0, 1'b0, produced, result);
                        dec_phase = ppcd_pkg::PH_HEAD;
                        rep_count = 9'd1;
                     end else begin
                        slot      = next_set(run_mask, 0);
                        dec_phase = ppcd_pkg::PH_GATHER;
                     end
                  end
               end
            end
         endcase
      end else begin
         if (slot < 3'd7) col_bytes[slot] = b;
         nxt = int'(slot) + 1;
         if (nxt < ppcd_pkg::CELL_BYTES) begin
            slot = 3'(nxt);
         end else begin
            slot = '0;
            // A track count lowered under the position moves to the next line.
            if (track_at >= tracks) begin
               track_at = '0;
               line_at  = line_at + 9'd1;
            end
            if (line_at >= lines) begin
               line_at  = 9'(lines);
               produced = 1'b1;
               result   = pack_write('0, '0, 9'd1, '0, '0, 1'b1);
            end else begin
               produced = 1'b1;
               result   = write_from_bytes(track_at[5:0], line_at[7:0], 9'd1,
                                           ppcd_pkg::FULL_MASK, 1'b0);
               track_at = track_at + 7'd1;
               if (track_at >= tracks) begin
                  track_at = '0;
                  line_at  = line_at + 9'd1;
               end
            end
         end
      end
      // The final byte of a pattern drops anything unfinished.
      if (beat.last_byte) restart_stream();
   endtask

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------

   // Offers one byte, keeps it steady until accepted, then predicts it.
   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input ppcd_pkg::rsp_beat_type typed_result);
      int gap;
      bit produced;
      ppcd_pkg::rsp_beat_type result;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         if (offering) begin
            req_valid <= 1'b0;
            offering = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, last};
      offering = 1'b1;
      // The beat moves at the first edge that sees ready high.
      do @(posedge clock); while (!req_ready);
      decode_byte({b, last}, produced, result);
      if (typed) pending_writes.push_back(typed_result);
      else if (produced) pending_writes.push_back(result);
      bytes_sent++;
   endtask

   // Random traffic marks about one byte in fifty as the end of a pattern,
   // which also breaks runs off in the middle now and then.
   task automatic offer(input logic [7:0] b);
      send_byte(b, 1'($urandom_range(0, 99) < 2), 1'b0, '0);
   endtask

   // Waits until every predicted write has arrived and the pipe is empty.
   task automatic drain_results();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Registers change only while the decoder holds nothing.
   task automatic write_csr(input logic [1:0] idx, input logic [8:0] val);
      drain_results();
      csr_index    <= idx;
      csr_wdata    <= val;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         ppcd_pkg::CSR_PACKED_MODE: cfg.packed_mode       = val[0];
         ppcd_pkg::CSR_LINES:       cfg.lines_in_pattern  = val;
         ppcd_pkg::CSR_TRACKS:      cfg.tracks_in_pattern = val[6:0];
         default: ;
      endcase
   endtask

   // One well-formed packed run with random content, or a stray byte.
   task automatic send_packed_run();
      int kind;
      bit counted;
      logic [6:0] m;
      counted = 1'b0;
      kind    = $urandom_range(0, 99);
      if (kind < 8) begin
         offer(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 99) < 30) begin
            offer(ppcd_pkg::BYTE_REPEAT);
            // Short repeats keep most runs on the grid; long ones clip.
            offer($urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                       : 8'($urandom_range(0, 255)));
            counted = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (counted && kind < 15) begin
            // The repeat byte right after a count is a full-mask head, so a
            // whole cell of column bytes follows it.
            offer(ppcd_pkg::BYTE_REPEAT);
            repeat (ppcd_pkg::CELL_BYTES) offer(8'($urandom_range(0, 255)));
         end else if (kind < 55) begin
            offer(8'($urandom_range(0, 127)));
            repeat (ppcd_pkg::CELL_BYTES - 1) offer(8'($urandom_range(0, 255)));
         end else begin
            m = ($urandom_range(0, 99) < 15) ? 7'd0 : 7'($urandom_range(1, 127));
            offer({1'b1, m});
            for (int k = 0; k < ppcd_pkg::CELL_BYTES; k++)
               if (m[k]) offer(8'($urandom_range(0, 255)));
         end
      end
   endtask

   function automatic void add_csr(logic [1:0] idx, logic [8:0] val);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.index = idx;
      r.value = val;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_byte(logic [7:0] b, logic last);
      stim_row_type r;
      r      = '0;
      r.kind = ROW_BYTE;
      r.beat = {b, last};
      directed_rows.push_back(r);
   endfunction

   function automatic void add_write(logic [7:0] b, logic last, ppcd_pkg::rsp_beat_type w);
      stim_row_type r;
      r        = '0;
      r.kind   = ROW_BYTE;
      r.beat   = {b, last};
      r.typed  = 1'b1;
      r.result = w;
      directed_rows.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int phase_no, goal;
      logic [8:0] val;

      cfg.packed_mode       = 1'b1;
      cfg.lines_in_pattern  = 9'd64;
      cfg.tracks_in_pattern = 7'd8;
      restart_stream();

      // Reset registers, packed mode. A plain head byte is column 0 of a
      // full-mask cell; the column bytes hit both byte extremes.
      add_byte(8'h12, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_byte(8'h01, 1'b0);
      add_write(8'hFE, 1'b0, pack_write(6'd0, 8'd0, 9'd1, ppcd_pkg::FULL_MASK,
                                        {8'h12, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE},
                                        1'b0));
      // The longest repeat, one column, clipped at the end of track 0.
      add_byte(ppcd_pkg::BYTE_REPEAT, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h81, 1'b0);
      add_write(8'hAA, 1'b0, pack_write(6'd0, 8'd1, 9'd63, 7'h01, {8'hAA, 48'd0}, 1'b1));
      // An empty mask skips a line; the end marker then clears the stream.
      add_byte(8'h80, 1'b1);
      // Zero registers act as a single line and a single track.
      add_csr(ppcd_pkg::CSR_LINES, 9'd0);
      add_csr(ppcd_pkg::CSR_TRACKS, 9'd0);
      add_byte(8'hC0, 1'b0);
      add_write(8'h33, 1'b0, pack_write(6'd0, 8'd0, 9'd1, 7'h40, {48'd0, 8'h33}, 1'b0));
      // The grid is now full, so the next run lands off it.
      add_byte(8'h81, 1'b0);
      add_write(8'h44, 1'b1, pack_write(6'd0, 8'd0, 9'd1, 7'd0, 56'd0, 1'b1));
      // Raw mode with registers above their range.
      add_csr(ppcd_pkg::CSR_PACKED_MODE, 9'd0);
      add_csr(ppcd_pkg::CSR_LINES, 9'd511);
      add_csr(ppcd_pkg::CSR_TRACKS, 9'h1FF);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_byte(8'hFE, 1'b0);
      add_write(8'h5A, 1'b1, pack_write(6'd0, 8'd0, 9'd1, ppcd_pkg::FULL_MASK,
                                        {8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h5A},
                                        1'b0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].index, directed_rows[i].value);
         else
            send_byte(directed_rows[i].beat.data_byte, directed_rows[i].beat.last_byte,
                      directed_rows[i].typed, directed_rows[i].result);
      end

      // Random phases. Each one starts with the decoder empty and may change
      // any register; the stream is not cleared between phases, so a mode or
      // size change often lands in the middle of a run or a cell.
      phase_no = 0;
      while (bytes_sent < TOTAL_BYTES) begin
         drain_results();
         idle_pct = (phase_no >= 4 && phase_no < 7) ? 0 : 19;
         if (phase_no == 2) begin
            // Largest grid, then the receiver holds off for a long stretch
            // while bytes keep coming, until the decoder stalls its input.
            write_csr(ppcd_pkg::CSR_PACKED_MODE, 9'd1);
            write_csr(ppcd_pkg::CSR_LINES, 9'd256);
            write_csr(ppcd_pkg::CSR_TRACKS, 9'd64);
            hold_request = 1'b1;
         end else begin
            if ($urandom_range(0, 99) < 50)
               write_csr(ppcd_pkg::CSR_PACKED_MODE, 9'($urandom_range(0, 99) < 70));
            if ($urandom_range(0, 99) < 50) begin
               case ($urandom_range(0, 7))
                  0:       val = 9'd0;
                  1:       val = 9'd1;
                  2, 3:    val = 9'($urandom_range(2, 8));
                  4:       val = 9'($urandom_range(1, 256));
                  5:       val = 9'd256;
                  6:       val = 9'($urandom_range(257, 511));
                  default: val = 9'd64;
               endcase
               write_csr(ppcd_pkg::CSR_LINES, val);
            end
            if ($urandom_range(0, 99) < 50) begin
               // Values above 127 also toggle the bits the register drops.
               case ($urandom_range(0, 7))
                  0:       val = 9'd0;
                  1:       val = 9'd1;
                  2, 3:    val = 9'($urandom_range(2, 4));
                  4:       val = 9'($urandom_range(1, 64));
                  5:       val = 9'd64;
                  6:       val = 9'($urandom_range(65, 511));
                  default: val = 9'd8;
               endcase
               write_csr(ppcd_pkg::CSR_TRACKS, val);
            end
         end
         goal = bytes_sent + $urandom_range(40, 120);
         while (bytes_sent < goal) begin
            if (cfg.packed_mode) send_packed_run();
            else repeat (ppcd_pkg::CELL_BYTES) offer(8'($urandom_range(0, 255)));
         end
         phase_no++;
      end

      drain_results();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver side and checking
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [8:0] want,
                              input logic [8:0] got);
      if (want !== got) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Samples at each edge the values from before it; a beat moves when valid
   // and ready were both high.
   initial begin : result_side
      ppcd_pkg::rsp_beat_type want;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_writes.size() == 0) begin
               mismatches++;
               $error("cell write beat arrived with none expected");
            end else begin
               want = pending_writes.pop_front();
               check_field("track_index", 9'(want.track_index),
                           9'(rsp_data.track_index));
               check_field("first_line",  9'(want.first_line), 9'(rsp_data.first_line));
               check_field("line_run",    want.line_run,       rsp_data.line_run);
               check_field("column_mask", 9'(want.column_mask),
                           9'(rsp_data.column_mask));
               check_field("col_0",       9'(want.col_0),      9'(rsp_data.col_0));
               check_field("col_1",       9'(want.col_1),      9'(rsp_data.col_1));
               check_field("col_2",       9'(want.col_2),      9'(rsp_data.col_2));
               check_field("col_3",       9'(want.col_3),      9'(rsp_data.col_3));
               check_field("col_4",       9'(want.col_4),      9'(rsp_data.col_4));
               check_field("col_5",       9'(want.col_5),      9'(rsp_data.col_5));
               check_field("col_6",       9'(want.col_6),      9'(rsp_data.col_6));
               check_field("overrun",     9'(want.overrun),    9'(rsp_data.overrun));
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

endmodule

// File: sim.f
rtl/ppcd_pkg.sv
rtl/ppcd_in_reg.sv
rtl/ppcd_engine.sv
rtl/ppcd_out_reg.sv
rtl/packed_pattern_cell_decoder.sv
tb/packed_pattern_cell_decoder_tb.sv
